>>> rtl/tbbq_pkg.sv
package tbbq_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int AW           = $clog2(BUFFER_BYTES);
    localparam int LW           = AW + 1;
    localparam int MEM_DEPTH    = 3 * BUFFER_BYTES;
    localparam int MW           = AW + 2;
    localparam int CW           = 14;
    localparam int TW           = 13;
    localparam int IN_W         = 24;
    localparam int OUT_W        = 56;

    localparam logic [TW-1:0] THRESHOLD_RESET = TW'(BUFFER_BYTES / 10);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_POP   = 2'd1,
        OP_SKIP  = 2'd2,
        OP_SWAP  = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic do_write;
        logic pop_check;
        logic pop_step;
        logic skip_step;
        logic swap_step;
        logic respond;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic out_busy;
        logic pop_ok;
        logic pop_last;
        logic skip_more;
        logic swap_last;
    } stat_t;

    function automatic logic [1:0] next3(input logic [1:0] x);
        next3 = (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

endpackage

>>> rtl/tbbq_ctrl.sv
module tbbq_ctrl
    import tbbq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_POP  = 6'b000100,
        S_SKIP = 6'b001000,
        S_SWAP = 6'b010000,
        S_RESP = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE) && !st.out_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (st.op)
                    OP_WRITE: begin
                        cmd.do_write = 1'b1;
                        state_next   = S_RESP;
                    end
                    OP_POP: begin
                        cmd.pop_check = 1'b1;
                        state_next    = st.pop_ok ? S_POP : S_RESP;
                    end
                    OP_SKIP: state_next = S_SKIP;
                    OP_SWAP: state_next = S_SWAP;
                    default: state_next = S_RESP;
                endcase
            end
            S_POP: begin
                cmd.pop_step = 1'b1;
                if (st.pop_last) begin
                    state_next = S_RESP;
                end
            end
            S_SKIP: begin
                cmd.skip_step = 1'b1;
                if (!st.skip_more) begin
                    state_next = S_RESP;
                end
            end
            S_SWAP: begin
                cmd.swap_step = 1'b1;
                if (st.swap_last) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> rtl/tbbq_dp.sv
module tbbq_dp
    import tbbq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             cfg_we,
    input  logic [TW-1:0]    cfg_wdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    input  cmd_t             cmd,
    output stat_t            st
);

    logic [7:0]    mem [0:MEM_DEPTH-1];
    logic [7:0]    mem_q;

    op_t           op_reg;
    logic [7:0]    data_reg;
    logic [CW-1:0] rem_reg;
    logic [2:0]    cnt_reg;
    logic [1:0]    ws_reg;
    logic [LW-1:0] pos_reg [0:2];
    logic [LW-1:0] len_reg [0:2];
    logic          rdf_reg, wdf_reg, dirty_reg, status_reg;
    logic [31:0]   word_reg;
    logic [TW-1:0] thr_reg;
    logic          ovalid_reg;
    logic [OUT_W-1:0] odata_reg;

    logic [1:0]    old_b, new_b, src_b;
    logic [LW-1:0] src_pos, src_len, left, wpos, wlen;
    logic [1:0]    dcnt;
    logic [1:0]    lane;
    logic [MW-1:0] rd_addr, wr_addr;
    logic [7:0]    wr_data;
    logic          wr_en;
    logic          full;

    assign old_b   = next3(ws_reg);
    assign new_b   = next3(old_b);
    assign src_b   = (pos_reg[old_b] == len_reg[old_b]) ? new_b : old_b;
    assign src_pos = pos_reg[src_b];
    assign src_len = len_reg[src_b];
    assign left    = src_len - src_pos;
    assign wpos    = pos_reg[ws_reg];
    assign wlen    = len_reg[ws_reg];
    assign dcnt    = wlen[1:0];
    assign full    = (wpos == LW'(BUFFER_BYTES));
    assign lane    = 2'(cnt_reg - 3'd1);

    assign st.op        = op_reg;
    assign st.out_busy  = ovalid_reg;
    assign st.pop_ok    = (left >= LW'(4));
    assign st.pop_last  = (cnt_reg == 3'd4);
    assign st.skip_more = (left != '0) && ({1'b0, left} < rem_reg) && (src_b == old_b);
    assign st.swap_last = (cnt_reg == {1'b0, dcnt});

    always_comb begin
        if (cmd.swap_step) begin
            rd_addr = {ws_reg, AW'(wlen - LW'(dcnt) + LW'(cnt_reg))};
        end else begin
            rd_addr = {src_b, AW'(src_pos + LW'(cnt_reg))};
        end
        if (cmd.swap_step) begin
            wr_en   = (cnt_reg != 3'd0);
            wr_addr = {next3(ws_reg), AW'(cnt_reg - 3'd1)};
            wr_data = mem_q;
        end else begin
            wr_en   = cmd.do_write && !full;
            wr_addr = {ws_reg, wpos[AW-1:0]};
            wr_data = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mem_q <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= op_t'(s_tdata[1:0]);
            data_reg   <= s_tdata[9:2];
            rem_reg    <= s_tdata[23:10];
            cnt_reg    <= '0;
            word_reg   <= '0;
        end
        if (cmd.pop_step) begin
            if (cnt_reg != 3'd0) begin
                word_reg[8*lane +: 8] <= mem_q;
            end
            cnt_reg <= st.pop_last ? 3'd0 : cnt_reg + 3'd1;
        end
        if (cmd.swap_step) begin
            cnt_reg <= cnt_reg + 3'd1;
        end
        if (cmd.skip_step && st.skip_more) begin
            rem_reg <= rem_reg - CW'(left);
        end
        if (cmd.respond) begin
            odata_reg <= {6'b0, dirty_reg, LW'(BUFFER_BYTES) - wpos, wdf_reg, rdf_reg,
                          (wlen >= thr_reg) && rdf_reg, status_reg, word_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg     <= '0;
            pos_reg    <= '{default: '0};
            len_reg    <= '{default: '0};
            rdf_reg    <= 1'b1;
            wdf_reg    <= 1'b0;
            dirty_reg  <= 1'b0;
            status_reg <= 1'b0;
            thr_reg    <= THRESHOLD_RESET;
            ovalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.load) begin
                status_reg <= 1'b0;
            end
            if (cmd.do_write) begin
                if (full) begin
                    status_reg <= 1'b1;
                end else begin
                    pos_reg[ws_reg] <= wpos + 1'b1;
                    len_reg[ws_reg] <= wlen + 1'b1;
                    if (wpos == LW'(BUFFER_BYTES - 1)) begin
                        wdf_reg <= 1'b1;
                    end
                end
            end
            if (cmd.pop_check && !st.pop_ok) begin
                status_reg <= 1'b1;
                if (left == '0) begin
                    rdf_reg <= 1'b1;
                end
            end
            if (cmd.pop_step && st.pop_last) begin
                pos_reg[src_b] <= src_pos + LW'(4);
            end
            if (cmd.skip_step) begin
                if (left == '0 && rem_reg != '0) begin
                    status_reg <= 1'b1;
                    rdf_reg    <= 1'b1;
                end else if (rem_reg <= {1'b0, left}) begin
                    pos_reg[src_b] <= src_pos + rem_reg[LW-1:0];
                    if (rem_reg == {1'b0, left}) begin
                        rdf_reg <= 1'b1;
                    end
                end else if (src_b == old_b) begin
                    pos_reg[old_b] <= src_len;
                end else begin
                    status_reg <= 1'b1;
                end
            end
            if (cmd.swap_step && st.swap_last) begin
                pos_reg[ws_reg] <= '0;
                len_reg[ws_reg] <= wlen - LW'(dcnt);
                pos_reg[old_b]  <= LW'(dcnt);
                len_reg[old_b]  <= LW'(dcnt);
                dirty_reg       <= (dcnt != 2'd0);
                ws_reg          <= old_b;
                rdf_reg         <= 1'b0;
                wdf_reg         <= 1'b0;
            end
            if (cmd.respond) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

endmodule

>>> rtl/triple_buffer_byte_queue.sv
// Triple-buffered byte queue: one buffer is filled, two are read oldest first.
// Input stream s_*: one transfer per operation (write byte, pop word, skip,
// swap). Output stream m_*: exactly one result transfer per input transfer,
// in order. Config: cfg_we/cfg_wdata set the swap threshold; write it only
// while idle.
// Timing: each item is taken, executed and placed in the output register
// before the next is accepted. A pop makes four reads of the single-read-port
// byte store, a skip takes one step per buffer it spans, and a swap copies
// its trailing bytes through the store one at a time. The next item is
// accepted only after the result transfer. s_tready is low while an item runs
// and while a result waits on m_tready; a stalled receiver holds off further
// input with no loss.
// Reset (aresetn low, synchronous) empties all buffers, sets reads finished,
// restores the threshold to 409; the byte store itself is not cleared.
module triple_buffer_byte_queue
    import tbbq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // operation, data_byte, skip_count
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // read_word, status, swap_allowed, reads_done,
                                        // writes_done, write_space, swap_was_dirty
    input  logic             cfg_we,
    input  logic [TW-1:0]    cfg_wdata
);

    cmd_t  cmd;
    stat_t st;

    tbbq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tbbq_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

>>> dv/testbench.sv
module testbench;
    import tbbq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [31:0]   word;
        logic          status;
        logic          ready;
        logic          rdone;
        logic          wdone;
        logic [TW-1:0] space;
        logic          dirty;
    } queue_result_t;

    class byte_queue_scoreboard;
        logic [7:0]    store [3][BUFFER_BYTES];
        int unsigned   wsel;
        int unsigned   pos [3];
        int unsigned   len [3];
        bit            rdone, wdone, dirty;
        logic [TW-1:0] thresh;
        queue_result_t awaited [$];
        int            errors;

        function void clear();
            wsel = 0;
            pos = '{0, 0, 0};
            len = '{0, 0, 0};
            rdone = 1;
            wdone = 0;
            dirty = 0;
            thresh = THRESHOLD_RESET;
            awaited.delete();
            errors = 0;
        endfunction

        function int unsigned read_buf();
            int unsigned old;
            old = (wsel + 1) % 3;
            return (pos[old] == len[old]) ? (wsel + 2) % 3 : old;
        endfunction

        function bit skip(int unsigned n);
            int unsigned b, left;
            b = read_buf();
            left = len[b] - pos[b];
            if (left == 0 && n > 0) begin
                rdone = 1;
                return 1;
            end
            if (n <= left) begin
                pos[b] += n;
                if (n == left) rdone = 1;
                return 0;
            end
            if (b == (wsel + 1) % 3) begin
                pos[b] = len[b];
                return skip(n - left);
            end
            return 1;
        endfunction

        function void note_input(op_t op, logic [7:0] data, logic [CW-1:0] cnt);
            queue_result_t r;
            int unsigned b, w, nw, d;
            r.word = '0;
            r.status = 0;
            case (op)
                OP_WRITE: begin
                    b = wsel;
                    if (pos[b] >= BUFFER_BYTES) begin
                        r.status = 1;
                    end else begin
                        store[b][pos[b]] = data;
                        if (pos[b] == BUFFER_BYTES - 1) wdone = 1;
                        pos[b]++;
                        len[b]++;
                    end
                end
                OP_POP: begin
                    b = read_buf();
                    if (pos[b] == len[b]) begin
                        rdone = 1;
                        r.status = 1;
                    end else if (len[b] - pos[b] < 4) begin
                        r.status = 1;
                    end else begin
                        for (int i = 0; i < 4; i++) r.word[8*i +: 8] = store[b][pos[b] + i];
                        pos[b] += 4;
                    end
                end
                OP_SKIP: r.status = skip(cnt);
                default: begin
                    w = wsel;
                    nw = (w + 1) % 3;
                    d = len[w] % 4;
                    for (int k = 0; k < d; k++) store[nw][k] = store[w][len[w] - d + k];
                    pos[w] = 0;
                    pos[nw] = d;
                    len[nw] = d;
                    len[w] -= d;
                    dirty = (d > 0);
                    wsel = nw;
                    rdone = 0;
                    wdone = 0;
                end
            endcase
            r.ready = (len[wsel] >= thresh) && rdone;
            r.rdone = rdone;
            r.wdone = wdone;
            r.space = TW'((pos[wsel] < BUFFER_BYTES) ? BUFFER_BYTES - pos[wsel] : 0);
            r.dirty = dirty;
            awaited.push_back(r);
        endfunction

        task report(string field, longint unsigned got, longint unsigned want);
            $display("mismatch at %0t: %s got %0h expected %0h", $time, field, got, want);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] t);
            queue_result_t e;
            if (awaited.size() == 0) begin
                report("unexpected transfer", t, 0);
                return;
            end
            e = awaited.pop_front();
            if (t[31:0] !== e.word) report("read_word", t[31:0], e.word);
            if (t[32] !== e.status) report("status", t[32], e.status);
            if (t[33] !== e.ready) report("swap_allowed", t[33], e.ready);
            if (t[34] !== e.rdone) report("reads_done", t[34], e.rdone);
            if (t[35] !== e.wdone) report("writes_done", t[35], e.wdone);
            if (t[48:36] !== e.space) report("write_space", t[48:36], e.space);
            if (t[49] !== e.dirty) report("swap_was_dirty", t[49], e.dirty);
        endtask
    endclass

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we = 0;
    logic [TW-1:0]    cfg_wdata = '0;

    byte_queue_scoreboard sb = new();
    bit calm;
    int holdoff_len;
    int stall_cycles;

    triple_buffer_byte_queue uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #10 aclk = ~aclk;

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            if (holdoff_len > 0) begin
                m_tready <= 0;
                holdoff_len--;
            end else begin
                m_tready <= calm || ($urandom % 100 >= 35);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task send(op_t op, logic [7:0] data = 0, logic [CW-1:0] cnt = 0);
        s_tvalid <= 1;
        s_tdata <= {cnt, data, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, data, cnt);
        if (!calm && $urandom % 100 < 35) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task set_threshold(logic [TW-1:0] v);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.thresh = v;
        @(posedge aclk);
    endtask

    task random_item();
        int r;
        r = $urandom % 100;
        if (r < 45) send(OP_WRITE, 8'($urandom));
        else if (r < 70) send(OP_POP);
        else if (r < 88) begin
            if ($urandom % 10 == 0) send(OP_SKIP, 8'($urandom), CW'($urandom_range(0, 16383)));
            else send(OP_SKIP, 8'($urandom), CW'($urandom_range(0, 12)));
        end else send(OP_SWAP, 8'($urandom), CW'($urandom));
    endtask

    initial begin
        sb.clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // empty queue, then dirty swap, word reads across buffers, rejected pops
        send(OP_POP);
        send(OP_SKIP, 0, 0);
        send(OP_SKIP, 0, 5);
        send(OP_WRITE, 8'h00);
        send(OP_WRITE, 8'hFF);
        send(OP_WRITE, 8'hA5);
        send(OP_WRITE, 8'h5A);
        send(OP_WRITE, 8'h01);
        send(OP_SWAP);
        send(OP_POP);
        send(OP_POP);
        for (int i = 0; i < 7; i++) send(OP_WRITE, 8'(8'h10 + i));
        send(OP_SWAP);
        send(OP_SKIP, 0, 2);
        send(OP_POP);
        send(OP_SKIP, 0, 2);
        send(OP_SKIP, 0, 0);
        send(OP_SWAP);
        send(OP_SKIP, 0, 14'h3FFF);
        drain();

        // threshold equal to the buffer size, oversized skips
        set_threshold(TW'(BUFFER_BYTES));
        calm = 1;
        for (int i = 0; i < 20; i++) send(OP_WRITE, 8'($urandom));
        send(OP_SWAP);
        send(OP_SKIP, 0, 8192);
        send(OP_SWAP);
        send(OP_SKIP, 0, 4100);
        drain();
        calm = 0;

        set_threshold(0);
        for (int i = 0; i < 140; i++) random_item();
        drain();

        set_threshold(TW'($urandom_range(1, 40)));
        for (int i = 0; i < 140; i++) begin
            if (i == 40) holdoff_len = 300;
            random_item();
        end
        drain();

        set_threshold(TW'($urandom_range(0, 8191)));
        calm = 1;
        for (int i = 0; i < 140; i++) random_item();
        calm = 0;
        drain();

        set_threshold(THRESHOLD_RESET);
        for (int i = 0; i < 140; i++) random_item();
        drain();

        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> triple_buffer_byte_queue.f
rtl/tbbq_pkg.sv
rtl/tbbq_ctrl.sv
rtl/tbbq_dp.sv
rtl/triple_buffer_byte_queue.sv
dv/testbench.sv
